// ===== sv/mdu_pkg.sv =====
package mdu_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned REG_W   = 64;
   localparam int unsigned IDX_W   = 5;
   localparam int unsigned STEPS   = DATA_W;
   localparam int unsigned CNT_W   = $clog2(STEPS);

   typedef enum logic [1:0] {
      ACT_SMUL = 2'd0,
      ACT_UMUL = 2'd1,
      ACT_SDIV = 2'd2,
      ACT_UDIV = 2'd3
   } mdu_action_type;

   typedef struct packed {
      mdu_action_type      action;
      logic [DATA_W-1:0]   rs_value;
      logic [DATA_W-1:0]   rt_value;
      logic [IDX_W-1:0]    dest_index;
   } mdu_req_type;

   typedef struct packed {
      logic [REG_W-1:0]    lo_value;
      logic [REG_W-1:0]    hi_value;
      logic                dest_write;
      logic [IDX_W-1:0]    dest_reg;
      logic [REG_W-1:0]    dest_value;
      logic                hilo_updated;
   } mdu_rsp_type;

   // Status of a bit-serial engine.
   typedef struct packed {
      logic busy;
      logic done;
   } mdu_eng_sts_type;

   function automatic logic [REG_W-1:0] sext32(input logic [DATA_W-1:0] w);
      return {{(REG_W-DATA_W){w[DATA_W-1]}}, w};
   endfunction

endpackage

// ===== sv/mdu_mul.sv =====
module mdu_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mdu_pkg::DATA_W-1:0]   mcand,
   input  logic [mdu_pkg::DATA_W-1:0]   mplier,
   output mdu_pkg::mdu_eng_sts_type     sts,
   output logic [mdu_pkg::REG_W-1:0]    product
);
   import mdu_pkg::*;

   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic [DATA_W-1:0] mcand_ff, hi_ff, hi_in, lo_ff, lo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DATA_W:0]   sum;

   // One multiplier bit per cycle: add the multiplicand when the bit is set,
   // then shift the partial product right.
   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         hi_in   = '0;
         lo_in   = mplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[DATA_W:1];
         lo_in  = {sum[0], lo_ff[DATA_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
      end
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = {hi_ff, lo_ff};

endmodule

// ===== sv/mdu_div.sv =====
module mdu_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mdu_pkg::DATA_W-1:0]   dividend,
   input  logic [mdu_pkg::DATA_W-1:0]   divisor,
   output mdu_pkg::mdu_eng_sts_type     sts,
   output logic [mdu_pkg::DATA_W-1:0]   quotient,
   output logic [mdu_pkg::DATA_W-1:0]   remainder
);
   import mdu_pkg::*;

   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic [DATA_W-1:0] dsr_ff, rem_ff, rem_in, quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W+1:0] diff;
   logic              fits;

   // Restoring division, one quotient bit per cycle. The remainder stays
   // below the divisor, so it always fits in a data word after the subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      fits    = ~diff[DATA_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dsr_ff <= divisor;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/mult_div_unit_hilo.sv =====
// A multiply or a divide runs through the 32 steps of its own radix-2 shift
// engine; a divide by zero skips the engines. A new transaction is taken only
// once the previous result has been handed to the output register.
// Reset (synchronous, active high) clears HI, LO, the control state and the
// result valid flag; no clearing pass is needed.
module mult_div_unit_hilo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mdu_pkg::mdu_req_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mdu_pkg::mdu_rsp_type  rsp_payload
);
   import mdu_pkg::*;

   // One-hot sequencer. IDLE takes a transaction, RUN waits for the engine
   // and DONE folds the signs back in and hands the result to the output
   // register as soon as that register is free.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } mdu_state_type;

   mdu_state_type state_ff, state_in;

   logic req_fire, rsp_fire, load_rsp;

   // Operand decode at accept time.
   logic              op_div, op_signed, dzero;
   logic [DATA_W-1:0] mag_a, mag_b;
   logic              neg_q, neg_r;

   // Per-transaction control kept while the engines run.
   logic             is_div_ff, neg_q_ff, neg_r_ff, dzero_ff;
   logic [IDX_W-1:0] dest_ff;

   // Architectural HI and LO registers.
   logic [REG_W-1:0] hi_ff, lo_ff;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   mdu_rsp_type rsp_ff, rsp_in;

   mdu_eng_sts_type   mul_sts, div_sts;
   logic [REG_W-1:0]  product, prod_fix;
   logic [DATA_W-1:0] quo, rem, quo_fix, rem_fix;
   logic [DATA_W-1:0] new_lo, new_hi;
   logic              mul_start, div_start;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Both engines work on magnitudes; signed operations negate afterwards.
   always_comb begin
      op_div    = (req_payload.action == ACT_SDIV) || (req_payload.action == ACT_UDIV);
      op_signed = (req_payload.action == ACT_SMUL) || (req_payload.action == ACT_SDIV);
      dzero     = op_div && (req_payload.rt_value == '0);
      mag_a     = (op_signed && req_payload.rs_value[DATA_W-1]) ?
                  (~req_payload.rs_value + 1'b1) : req_payload.rs_value;
      mag_b     = (op_signed && req_payload.rt_value[DATA_W-1]) ?
                  (~req_payload.rt_value + 1'b1) : req_payload.rt_value;
      // Quotient and product take the sign of a^b; the remainder that of a.
      neg_q     = op_signed && (req_payload.rs_value[DATA_W-1] ^
                                req_payload.rt_value[DATA_W-1]);
      neg_r     = op_signed && req_payload.rs_value[DATA_W-1];
   end

   assign mul_start = req_fire && !op_div;
   assign div_start = req_fire && op_div && !dzero;

   mdu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mag_a),
      .mplier  (mag_b),
      .sts     (mul_sts),
      .product (product)
   );

   mdu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_a),
      .divisor   (mag_b),
      .sts       (div_sts),
      .quotient  (quo),
      .remainder (rem)
   );

   // The most negative dividend over minus one comes out right on its own:
   // the magnitude quotient is 0x80000000 and, both signs being negative, it is not negated.
   always_comb begin
      prod_fix = neg_q_ff ? (~product + 1'b1) : product;
      quo_fix  = neg_q_ff ? (~quo + 1'b1) : quo;
      rem_fix  = neg_r_ff ? (~rem + 1'b1) : rem;
      new_lo   = is_div_ff ? quo_fix : prod_fix[DATA_W-1:0];
      new_hi   = is_div_ff ? rem_fix : prod_fix[REG_W-1:DATA_W];

      rsp_in = rsp_ff;
      if (dzero_ff) begin
         rsp_in.lo_value     = lo_ff;
         rsp_in.hi_value     = hi_ff;
         rsp_in.hilo_updated = 1'b0;
      end else begin
         rsp_in.lo_value     = sext32(new_lo);
         rsp_in.hi_value     = sext32(new_hi);
         rsp_in.hilo_updated = 1'b1;
      end
      rsp_in.dest_write = !is_div_ff && (dest_ff != '0);
      rsp_in.dest_reg   = rsp_in.dest_write ? dest_ff : '0;
      rsp_in.dest_value = rsp_in.dest_write ? rsp_in.lo_value : '0;

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = dzero ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (mul_sts.done || div_sts.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         is_div_ff <= op_div;
         neg_q_ff  <= neg_q;
         neg_r_ff  <= neg_r;
         dzero_ff  <= dzero;
         dest_ff   <= req_payload.dest_index;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hi_ff        <= '0;
         lo_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_rsp) begin
            hi_ff <= rsp_in.hi_value;
            lo_ff <= rsp_in.lo_value;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_one_engine: assert property (@(posedge clock) disable iff (reset)
      !(mul_sts.done && div_sts.done))
      else $error("both engines finished in the same cycle");

   a_run_engine: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |->
         (mul_sts.busy || mul_sts.done || div_sts.busy || div_sts.done))
      else $error("waiting for a result with no engine running");

   a_wb_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.dest_write) |-> (rsp_ff.dest_value == rsp_ff.lo_value))
      else $error("write-back value differs from LO");

   a_dzero_keep: assert property (@(posedge clock) disable iff (reset)
      load_rsp && dzero_ff |=> (lo_ff == $past(lo_ff)) && (hi_ff == $past(hi_ff)))
      else $error("divide by zero changed HI or LO");

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("second transaction taken while one is in progress");
`endif

endmodule

// ===== verif/mdu_hilo_checker.sv =====
module mdu_hilo_checker
   import mdu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  mdu_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  mdu_rsp_type rsp_payload,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Expected results in order of acceptance, and our own copy of HI and LO.
   mdu_rsp_type      expected_rsp_q[$];
   logic [REG_W-1:0] hi_track;
   logic [REG_W-1:0] lo_track;
   int               mismatch_total = 0;
   int               result_total   = 0;

   function automatic logic [REG_W-1:0] widen(input logic [DATA_W-1:0] w);
      return {{(REG_W-DATA_W){w[DATA_W-1]}}, w};
   endfunction

   // Works out the result of one transaction and updates the HI/LO copy.
   function automatic mdu_rsp_type predict_hilo(input mdu_req_type item);
      mdu_rsp_type       rsp;
      logic [REG_W-1:0]  product;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] mag_a;
      logic [DATA_W-1:0] mag_b;
      logic [DATA_W-1:0] quot;
      logic [DATA_W-1:0] rem;
      a = item.rs_value;
      b = item.rt_value;
      rsp = '0;
      rsp.hilo_updated = 1'b1;
      case (item.action)
         ACT_SMUL, ACT_UMUL: begin
            if (item.action == ACT_SMUL) begin
               product = widen(a) * widen(b);
            end else begin
               product = {{(REG_W-DATA_W){1'b0}}, a} * {{(REG_W-DATA_W){1'b0}}, b};
            end
            lo_track = widen(product[DATA_W-1:0]);
            hi_track = widen(product[REG_W-1:DATA_W]);
            if (item.dest_index != '0) begin
               rsp.dest_write = 1'b1;
               rsp.dest_reg   = item.dest_index;
               rsp.dest_value = lo_track;
            end
         end
         ACT_SDIV, ACT_UDIV: begin
            if (b == '0) begin
               rsp.hilo_updated = 1'b0;
            end else if (item.action == ACT_UDIV) begin
               quot = a / b;
               rem  = a % b;
               lo_track = widen(quot);
               hi_track = widen(rem);
            end else begin
               // Divide magnitudes, then fix signs: truncation toward zero.
               mag_a = a[DATA_W-1] ? -a : a;
               mag_b = b[DATA_W-1] ? -b : b;
               quot  = mag_a / mag_b;
               rem   = mag_a % mag_b;
               if (a[DATA_W-1] ^ b[DATA_W-1]) begin
                  quot = -quot;
               end
               if (a[DATA_W-1]) begin
                  rem = -rem;
               end
               lo_track = widen(quot);
               hi_track = widen(rem);
            end
         end
      endcase
      rsp.lo_value = lo_track;
      rsp.hi_value = hi_track;
      return rsp;
   endfunction

   task automatic check_field(input string name, input logic [REG_W-1:0] expected,
                              input logic [REG_W-1:0] actual);
      if (expected !== actual) begin
         $error("%s: expected 0x%h, actual 0x%h", name, expected, actual);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin
      mdu_rsp_type exp_rsp;
      if (reset) begin
         hi_track = '0;
         lo_track = '0;
         expected_rsp_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(predict_hilo(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            result_total++;
            if (expected_rsp_q.size() == 0) begin
               $error("result transaction arrived with no expectation waiting");
               mismatch_total++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               check_field("lo_value", exp_rsp.lo_value, rsp_payload.lo_value);
               check_field("hi_value", exp_rsp.hi_value, rsp_payload.hi_value);
               check_field("dest_write", REG_W'(exp_rsp.dest_write),
                           REG_W'(rsp_payload.dest_write));
               check_field("dest_reg", REG_W'(exp_rsp.dest_reg), REG_W'(rsp_payload.dest_reg));
               check_field("dest_value", exp_rsp.dest_value, rsp_payload.dest_value);
               check_field("hilo_updated", REG_W'(exp_rsp.hilo_updated),
                           REG_W'(rsp_payload.hilo_updated));
            end
         end
      end
      fail_count    <= mismatch_total;
      pending_count <= expected_rsp_q.size();
      checked_count <= result_total;
   end

endmodule

// ===== verif/tb_mult_div_unit_hilo.sv =====
// Testbench top for the multiply/divide unit. This module only generates
// stimulus and delivers the verdict; all prediction and comparison happens in
// the checker instance that watches both channels.
module tb_mult_div_unit_hilo;
   import mdu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Number of random transactions after the directed part, and how many of
   // the final ones run without any idling on either side.
   localparam int RANDOM_ITEMS     = 1600;
   localparam int QUIET_TAIL       = 200;
   // The long receiver hold-off starts once this many transactions went in.
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 400;
   // A correct run never goes without a handshake for longer than one operation plus
   // the idle bursts on both sides, or the long hold-off plus one operation; this is far beyond.
   localparam int IDLE_LIMIT       = 4000;
   localparam int DRAIN_CYCLES     = 40;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   mdu_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   mdu_rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int checked_count;

   // Stimulus bookkeeping. The two shared with the receiver process are
   // updated with nonblocking assignments so neither side races the other.
   int sent_count     = 0;
   bit idling_on      = 1'b1;
   int mul_count      = 0;
   int div_count      = 0;
   int zero_div_count = 0;
   int overflow_count = 0;

   int ready_hold     = 0;
   bit long_hold_done = 1'b0;
   int idle_cycles    = 0;

   always #5 clock = ~clock;

   mult_div_unit_hilo i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   mdu_hilo_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Receiver: random bursts of back-pressure, plus one long hold-off while
   // the sender keeps offering transactions, so the unit fills up and has to
   // stall its input side.
   always @(negedge clock) begin
      if (!reset) begin
         if (ready_hold == 0) begin
            if (!long_hold_done && sent_count >= LONG_HOLD_AT) begin
               ready_hold     = LONG_HOLD_CYCLES;
               long_hold_done = 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
               ready_hold = $urandom_range(1, 16);
            end
         end
         if (ready_hold != 0) begin
            rsp_ready <= 1'b0;
            ready_hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: counts cycles in which neither channel completes a
   // transaction. Reaching the limit means the unit hung or lost a result.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transaction.", IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // Offers one transaction, entered and left at a falling edge. An optional
   // idle burst comes first; valid is only lowered there, never between two
   // back-to-back transactions.
   task automatic send_req(input mdu_req_type item);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count <= sent_count + 1;
   endtask

   task automatic issue(input mdu_action_type action, input logic [DATA_W-1:0] rs,
                        input logic [DATA_W-1:0] rt, input logic [IDX_W-1:0] dest);
      mdu_req_type item;
      item.action     = action;
      item.rs_value   = rs;
      item.rt_value   = rt;
      item.dest_index = dest;
      if (action == ACT_SMUL || action == ACT_UMUL) begin
         mul_count++;
      end else begin
         div_count++;
         if (rt == '0) begin
            zero_div_count++;
         end
         if (action == ACT_SDIV && rs == 32'h8000_0000 && rt == 32'hFFFF_FFFF) begin
            overflow_count++;
         end
      end
      send_req(item);
   endtask

   // Operands lean toward the boundaries of the 32-bit range, with small
   // positive and negative values and fully random words mixed in.
   function automatic logic [DATA_W-1:0] pick_operand();
      logic [DATA_W-1:0] corners [8];
      int                choice;
      corners = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      choice = $urandom_range(0, 7);
      case (choice)
         0, 1:    return corners[$urandom_range(0, 7)];
         2:       return DATA_W'($urandom_range(0, 255));
         3:       return -DATA_W'($urandom_range(1, 255));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      mdu_action_type    action;
      logic [DATA_W-1:0] rs;
      logic [DATA_W-1:0] rt;
      logic [IDX_W-1:0]  dest;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: extreme products, sign handling of the divide,
      // nonzero destinations on divides, the overflow quotient, and divides
      // by zero that must leave HI and LO as the previous operation set them.
      issue(ACT_SMUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1);
      issue(ACT_SMUL, 32'h8000_0000, 32'h8000_0000, 5'd31);
      issue(ACT_SMUL, 32'h8000_0000, 32'hFFFF_FFFF, 5'd0);
      issue(ACT_SMUL, 32'hFFFF_FFFF, 32'h0000_0001, 5'd5);
      issue(ACT_UMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      issue(ACT_UMUL, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0);
      issue(ACT_UMUL, 32'h8000_0000, 32'h0000_0002, 5'd7);
      issue(ACT_SDIV, 32'h0000_0007, 32'h0000_0002, 5'd0);
      issue(ACT_SDIV, 32'hFFFF_FFF9, 32'h0000_0002, 5'd3);
      issue(ACT_SDIV, 32'h0000_0007, 32'hFFFF_FFFE, 5'd0);
      issue(ACT_SDIV, 32'hFFFF_FFF9, 32'hFFFF_FFFE, 5'd30);
      issue(ACT_SDIV, 32'h8000_0000, 32'hFFFF_FFFF, 5'd31);
      issue(ACT_SDIV, 32'h8000_0000, 32'h0000_0001, 5'd0);
      issue(ACT_SDIV, 32'h7FFF_FFFF, 32'h8000_0000, 5'd2);
      issue(ACT_SDIV, 32'h0000_0005, 32'h0000_0000, 5'd9);
      issue(ACT_UDIV, 32'hFFFF_FFFF, 32'h0000_0001, 5'd31);
      issue(ACT_UDIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
      issue(ACT_UDIV, 32'h0000_0001, 32'hFFFF_FFFF, 5'd4);
      issue(ACT_UDIV, 32'h0000_0000, 32'h0000_0000, 5'd0);
      issue(ACT_UDIV, 32'h1234_5678, 32'h0000_0010, 5'd0);
      issue(ACT_SMUL, 32'h0000_0000, 32'h0000_0000, 5'd0);
      issue(ACT_UDIV, 32'h8000_0000, 32'h0000_0000, 5'd31);
      issue(ACT_SDIV, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0);

      // Random part. Divisors of zero and the overflow pair are injected on
      // purpose since random words would almost never hit them.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_TAIL) begin
            idling_on <= 1'b0;
         end
         action = mdu_action_type'($urandom_range(0, 3));
         rs     = pick_operand();
         rt     = pick_operand();
         if ($urandom_range(0, 15) == 0) begin
            rt = '0;
         end else if (action == ACT_SDIV && $urandom_range(0, 31) == 0) begin
            rs = 32'h8000_0000;
            rt = 32'hFFFF_FFFF;
         end
         dest = ($urandom_range(0, 3) == 0) ? '0 : IDX_W'($urandom_range(0, 31));
         issue(action, rs, rt, dest);
      end
      req_valid <= 1'b0;

      // Drain: the watchdog catches a result that never arrives.
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transactions: %0d multiplies, %0d divides (%0d by zero, %0d overflow).",
               mul_count + div_count, mul_count, div_count, zero_div_count, overflow_count);
      $display("Compared %0d results; the receiver held off once for %0d cycles under load.",
               checked_count, LONG_HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mdu_pkg.sv
sv/mdu_mul.sv
sv/mdu_div.sv
sv/mult_div_unit_hilo.sv
verif/mdu_hilo_checker.sv
verif/tb_mult_div_unit_hilo.sv
